// ===== src/kvt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the key/value table.
// No dependencies.
package kvt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 6;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_ERASE  = 3'd2,
    FUNC_LOOKUP = 3'd3,
    FUNC_COUNT  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_DUP     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_DONE  = 2'd2
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  found_value;
    logic [CNT_W-1:0]  match_count;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  // Search token carried down the cell row.
  typedef struct packed {
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              hit;
    logic [VAL_W-1:0]  found;
    logic [CNT_W-1:0]  match_cnt;
    logic [KEY_W-1:0]  last_key;
    logic [VAL_W-1:0]  last_value;
  } tok_t;

  // Entry write broadcast to the row.
  typedef struct packed {
    logic              en;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } wr_t;

endpackage

// ===== src/kvt_cell.sv =====
`timescale 1ns / 1ps
// One table entry: holds a key and value and updates the passing search token.
// Depends on kvt_pkg.
module kvt_cell import kvt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned OCC_W    = 6,
  parameter int unsigned SLOT_W   = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OCC_W-1:0]  occ_i,
  input  wr_t               wr_i,
  input  logic [SLOT_W-1:0] wr_idx_i,
  input  logic              tok_valid_i,
  input  tok_t              tok_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              tok_valid_o,
  output tok_t              tok_o,
  output logic [SLOT_W-1:0] slot_o
);

  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic              live;
  logic              last;
  tok_t              tok_d, tok_q;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic              valid_q;

  assign live = OCC_W'(CELL_IDX) < occ_i;
  assign last = OCC_W'(CELL_IDX + 1) == occ_i;

  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_i;
    if (live && (key_q == tok_i.key) && !tok_i.hit) begin
      tok_d.hit   = 1'b1;
      tok_d.found = val_q;
      slot_d      = SLOT_W'(CELL_IDX);
    end
    if (live && (val_q == tok_i.value)) begin
      tok_d.match_cnt = tok_i.match_cnt + CNT_W'(1);
    end
    if (last) begin
      tok_d.last_key   = key_q;
      tok_d.last_value = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_idx_i == SLOT_W'(CELL_IDX))) begin
      key_q <= wr_i.key;
      val_q <= wr_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign slot_o      = slot_q;

endmodule

// ===== src/key_value_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the key/value table: cell row, sequencer, result register.
// Depends on kvt_pkg and kvt_cell.
//
//  channel | valid       | ready       | beat
//  --------+-------------+-------------+-------------------------------
//  request | req_valid_i | req_ready_o | req_i  (func, key, value)
//  result  | rsp_valid_o | rsp_ready_i | rsp_o  (status, found_value,
//          |             |             |         match_count, entry_count)
//
// The search token walks the cell row one cell per cycle; at the end of the
// row it is captured in S_SWEEP, then committed in S_DONE into the result register.
// A new request is taken only in S_IDLE, once the previous result is registered.
// Reset clears the entry count and all control; entries need no clearing.
// A held result stalls only the commit of the following item.
module key_value_table_unit import kvt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned OCC_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_e             state_q, state_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  tok_t               done_q, done_d;
  logic [SLOT_W-1:0]  done_slot_q, done_slot_d;
  rsp_t               rsp_q, rsp_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic               accept;
  logic               commit;
  wr_t                wr;
  logic [SLOT_W-1:0]  wr_idx;

  logic [TABLE_DEPTH:0] vld_chain;
  tok_t                 tok_chain  [TABLE_DEPTH+1];
  logic [SLOT_W-1:0]    slot_chain [TABLE_DEPTH+1];

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  assign tok_chain[0]  = '{func: req_i.func, key: req_i.key, value: req_i.value,
                           default: '0};
  assign slot_chain[0] = '0;
  assign vld_chain[0]  = accept;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kvt_cell #(
      .CELL_IDX (i),
      .OCC_W    (OCC_W),
      .SLOT_W   (SLOT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .occ_i       (occ_q),
      .wr_i        (wr),
      .wr_idx_i    (wr_idx),
      .tok_valid_i (vld_chain[i]),
      .tok_i       (tok_chain[i]),
      .slot_i      (slot_chain[i]),
      .tok_valid_o (vld_chain[i+1]),
      .tok_o       (tok_chain[i+1]),
      .slot_o      (slot_chain[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    done_d      = done_q;
    done_slot_d = done_slot_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    commit      = 1'b0;
    wr          = '0;
    wr_idx      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (vld_chain[TABLE_DEPTH]) begin
          done_d      = tok_chain[TABLE_DEPTH];
          done_slot_d = slot_chain[TABLE_DEPTH];
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          commit             = 1'b1;
          state_d            = S_IDLE;
          rsp_valid_d        = 1'b1;
          rsp_d.status       = STATUS_OK;
          rsp_d.found_value  = '0;
          rsp_d.match_count  = '0;
          case (done_q.func)
            FUNC_CLEAR: begin
              occ_d = '0;
            end
            FUNC_INSERT: begin
              if (done_q.hit) begin
                rsp_d.status = STATUS_DUP;
              end else if (occ_q >= OCC_W'(TABLE_DEPTH)) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                wr.en    = 1'b1;
                wr.key   = done_q.key;
                wr.value = done_q.value;
                wr_idx   = SLOT_W'(occ_q);
                occ_d    = occ_q + OCC_W'(1);
              end
            end
            FUNC_ERASE: begin
              if (!done_q.hit) begin
                rsp_d.status = STATUS_MISSING;
              end else begin
                wr.en    = 1'b1;
                wr.key   = done_q.last_key;
                wr.value = done_q.last_value;
                wr_idx   = done_slot_q;
                occ_d    = occ_q - OCC_W'(1);
              end
            end
            FUNC_LOOKUP: begin
              if (!done_q.hit) begin
                rsp_d.status = STATUS_MISSING;
              end else begin
                rsp_d.found_value = done_q.found;
              end
            end
            FUNC_COUNT: begin
              rsp_d.match_count = done_q.match_cnt;
            end
            default: begin
            end
          endcase
          rsp_d.entry_count = CNT_W'(occ_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q      <= done_d;
    done_slot_q <= done_slot_d;
    rsp_q       <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_chain))
    else $error("more than one search token in the cell row");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SWEEP) && vld_chain[1])
    else $error("accepted request did not enter the cell row");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && ((rsp_d.status == STATUS_FULL) || (rsp_d.status == STATUS_DUP)))
      |=> $stable(occ_q))
    else $error("refused insert changed the entry count");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_valid_q && (rsp_q.entry_count == CNT_W'(occ_q)))
    else $error("result entry count disagrees with table");

endmodule

// ===== tb/tb_key_value_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for key_value_table_unit: directed and random table operations,
// each result checked against an in-bench shadow of the table. Depends on kvt_pkg.
module tb_key_value_table_unit;
  import kvt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 32;
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned ITEM_LATENCY = TABLE_DEPTH + 2;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [2:0]  FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_beat  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_beat;

  logic [KEY_W-1:0] shadow_keys   [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_values [TABLE_DEPTH];
  int unsigned      shadow_live   = 0;
  logic [VAL_W-1:0] value_pool    [4];
  rsp_t             expected_results [$];
  int unsigned      fault_count  = 0;
  int unsigned      quiet_cycles = 0;
  bit               idling_on    = 1'b1;

  key_value_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req_beat),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp_beat)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Apply one operation to the shadow table and return the result it must give.
  function automatic rsp_t table_apply(req_t op);
    rsp_t        res;
    int unsigned slot;
    int unsigned match_total;
    bit          hit;
    res         = '0;
    slot        = 0;
    match_total = 0;
    hit         = 1'b0;
    for (int unsigned i = 0; i < shadow_live; i++) begin
      if (!hit && shadow_keys[i] == op.key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    res.status = STATUS_OK;
    case (op.func)
      FUNC_CLEAR: begin
        shadow_live = 0;
      end
      FUNC_INSERT: begin
        if (hit) begin
          res.status = STATUS_DUP;
        end else if (shadow_live >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_keys[shadow_live]   = op.key;
          shadow_values[shadow_live] = op.value;
          shadow_live++;
        end
      end
      FUNC_ERASE: begin
        if (!hit) begin
          res.status = STATUS_MISSING;
        end else begin
          shadow_live--;
          shadow_keys[slot]   = shadow_keys[shadow_live];
          shadow_values[slot] = shadow_values[shadow_live];
        end
      end
      FUNC_LOOKUP: begin
        if (!hit) begin
          res.status = STATUS_MISSING;
        end else begin
          res.found_value = shadow_values[slot];
        end
      end
      FUNC_COUNT: begin
        for (int unsigned i = 0; i < shadow_live; i++) begin
          if (shadow_values[i] == op.value) match_total++;
        end
      end
      default: begin
      end
    endcase
    res.match_count = match_total[CNT_W-1:0];
    res.entry_count = shadow_live[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin : beat_monitor
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("unexpected result: status=%0d found=%h match=%0d entries=%0d",
                     rsp_beat.status, rsp_beat.found_value, rsp_beat.match_count,
                     rsp_beat.entry_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (rsp_beat.status !== want.status || rsp_beat.found_value !== want.found_value ||
              rsp_beat.match_count !== want.match_count ||
              rsp_beat.entry_count !== want.entry_count) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("mismatch: exp status=%0d found=%h match=%0d entries=%0d",
                       want.status, want.found_value, want.match_count, want.entry_count);
              $display("          got status=%0d found=%h match=%0d entries=%0d",
                       rsp_beat.status, rsp_beat.found_value, rsp_beat.match_count,
                       rsp_beat.entry_count);
            end
          end
        end
      end
      if (req_valid && req_ready) expected_results.push_back(table_apply(req_beat));
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_key_value_table_unit failed");
    $finish;
  end

  // Result side: stall in random bursts while idling is on.
  initial begin
    @(posedge rst_ni);
    rsp_ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_op(input func_e op_func, input logic [KEY_W-1:0] op_key,
                         input logic [VAL_W-1:0] op_value);
    req_beat  <= '{func: op_func, key: op_key, value: op_value};
    req_valid <= 1'b1;
    do @(posedge clk_i); while (!req_ready);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Hold off the request side until every pending result has come back.
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned reuse_pct);
    if (shadow_live != 0 && $urandom_range(0, 99) < reuse_pct) begin
      return shadow_keys[$urandom_range(0, shadow_live - 1)];
    end
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_target();
    if (shadow_live != 0 && $urandom_range(0, 9) < 6) begin
      return shadow_values[$urandom_range(0, shadow_live - 1)];
    end
    return pick_value();
  endfunction

  task automatic test_empty_table();
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(FUNC_ERASE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(FUNC_COUNT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int unsigned code = FUNC_SPARE_LO; code <= FUNC_SPARE_HI; code++) begin
      send_op(func_e'(code[2:0]), $urandom(), $urandom());
    end
  endtask

  task automatic test_insert_extremes();
    send_op(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'h0000_0005);
    send_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(FUNC_COUNT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(FUNC_COUNT, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_erase_reorder();
    send_op(FUNC_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hA5A5_0001, 32'h0000_0001);
    send_op(FUNC_INSERT, 32'h5A5A_0002, 32'h0000_0002);
    send_op(FUNC_INSERT, 32'h8000_0003, 32'h0000_0002);
    send_op(FUNC_ERASE, 32'hA5A5_0001, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'h8000_0003, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'h5A5A_0002, 32'h0000_0000);
    send_op(FUNC_COUNT, 32'h0000_0000, 32'h0000_0002);
    send_op(FUNC_ERASE, 32'hA5A5_0001, 32'h0000_0000);
    send_op(FUNC_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_LOOKUP, 32'h8000_0003, 32'h0000_0000);
  endtask

  task automatic test_fill_overflow();
    logic [VAL_W-1:0] shared;
    bit               same_value;
    shared     = pick_value();
    same_value = $urandom_range(0, 1);
    send_op(FUNC_CLEAR, $urandom(), $urandom());
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      send_op(FUNC_INSERT, $urandom(), same_value ? shared : pick_value());
    end
    send_op(FUNC_INSERT, $urandom(), $urandom());
    send_op(FUNC_INSERT, shadow_keys[0], $urandom());
    send_op(FUNC_COUNT, $urandom(), shared);
    repeat (6) begin
      send_op(FUNC_LOOKUP, pick_key(100), $urandom());
      send_op(FUNC_ERASE, pick_key(100), $urandom());
      send_op(FUNC_INSERT, $urandom(), pick_value());
      send_op(FUNC_LOOKUP, $urandom(), $urandom());
    end
  endtask

  task automatic test_random_ops(input int unsigned n_items);
    int unsigned roll;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 42) begin
        send_op(FUNC_INSERT, pick_key(20), pick_value());
      end else if (roll < 60) begin
        send_op(FUNC_ERASE, pick_key(70), $urandom());
      end else if (roll < 82) begin
        send_op(FUNC_LOOKUP, pick_key(70), $urandom());
      end else if (roll < 94) begin
        send_op(FUNC_COUNT, $urandom(), pick_target());
      end else if (roll < 96) begin
        send_op(FUNC_CLEAR, $urandom(), $urandom());
      end else begin
        send_op(func_e'(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))),
                $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom()};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_insert_extremes();
    test_erase_reorder();
    wait_for_results();
    repeat (4) test_fill_overflow();
    test_random_ops(1100);
    wait_for_results();
    idling_on = 1'b0;
    test_random_ops(300);
    wait_for_results();
    repeat (ITEM_LATENCY + 8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb_key_value_table_unit passed");
    end else begin
      $display("tb_key_value_table_unit failed");
    end
    $finish;
  end

endmodule
